// File: sv/spq_pkg.sv
// spq_pkg: shared constants, status codes and cell control struct
// for the sorted priority queue; used by spq_cell and sorted_priority_queue
`default_nettype none

package spq_pkg;

  // queue geometry
  localparam int DEPTH   = 8;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int VAL_W   = 32;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 4;

  // item commands
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_DELETE = 1'b1;

  // result status codes
  localparam logic [STAT_W-1:0] ST_DONE     = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

  // broadcast from control to every cell
  typedef struct packed {
    logic                    ins;    // insert goes ahead this cycle
    logic                    del;    // delete of a held value goes ahead
    logic signed [VAL_W-1:0] value;  // operand of the item
  } spq_ctl_t;

endpackage

`default_nettype wire

// File: sv/spq_cell.sv
// spq_cell: one slot of the sorted row; compares the broadcast value with
// its entry and shifts with its neighbors on insert or delete; uses spq_pkg
`default_nettype none

module spq_cell (
  input  wire                              clk,
  input  wire                              rst_n,
  input  spq_pkg::spq_ctl_t                ctl,
  input  wire                              left_vld,   // left slot held
  input  wire                              left_ge,    // value >= left entry
  input  wire  signed [spq_pkg::VAL_W-1:0] left_ent,
  input  wire                              right_vld,
  input  wire  signed [spq_pkg::VAL_W-1:0] right_ent,
  output logic signed [spq_pkg::VAL_W-1:0] ent_r,
  output logic                             vld_r,
  output logic                             ge,         // value >= own entry
  output logic                             eq,         // value == own entry
  output logic signed [spq_pkg::VAL_W-1:0] ent_nxt,
  output logic                             vld_nxt
);
  import spq_pkg::*;

  logic ins_shift;
  logic ins_take;
  logic del_shift;

  // local compare against the broadcast value
  assign ge = (ctl.value >= ent_r);
  assign eq = (ctl.value == ent_r);

  // insert: take the left entry when the value is at or above it, or take the value here
  assign ins_shift = left_vld && left_ge;
  assign ins_take  = left_vld && !left_ge && (!vld_r || ge);

  // delete: every held slot at or after the first equal entry pulls from the right
  assign del_shift = vld_r && ge;

  // next entry and held flag
  always_comb begin
    ent_nxt = ent_r;
    vld_nxt = vld_r;
    if (ctl.ins) begin
      if (ins_shift) begin
        ent_nxt = left_ent;
      end else if (ins_take) begin
        ent_nxt = ctl.value;
      end
      vld_nxt = vld_r || left_vld;
    end else if (ctl.del) begin
      if (del_shift) begin
        ent_nxt = right_ent;
        vld_nxt = right_vld;
      end
    end
  end

  // slot registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    ent_r <= ent_nxt;
  end

endmodule

`default_nettype wire

// File: sv/sorted_priority_queue.sv
// sorted_priority_queue: top level; row of spq_cell slots kept largest first,
// item control, held count and the result register; uses spq_pkg and spq_cell
`default_nettype none

//  channel | ports          | fields (lowest bit first)
//  --------+----------------+--------------------------------------------
//  in      | in_t*          | tuser: command; tdata: value[31:0]
//  out     | out_t*         | tdata: status[1:0], count[5:2], top[37:6]
//
//  One item per cycle unless a held result stalls: every slot compares
//  the value and shifts with its neighbors in the same cycle, so the result
//  is registered in the cycle after the item is taken. The longest path runs
//  through the found flag, an OR over all slots, into the delete control of
//  every slot. Synchronous reset empties the queue (held count and slot flags
//  cleared). A stalled result blocks new items only while out_tready is low.

module sorted_priority_queue (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [31:0] in_tdata,   // value[31:0]
  input  wire         in_tuser,   // command
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [39:0] out_tdata   // status[1:0], count[5:2], top_value[37:6], zero
);
  import spq_pkg::*;

  logic                    step;
  logic                    full;
  logic                    found;
  spq_ctl_t                ctl;
  logic [CNT_W-1:0]        held_r;
  logic [CNT_W-1:0]        held_nxt;
  logic [STAT_W-1:0]       status;
  logic [CNT_W+COUNT_W-1:0] cnt_ext;

  logic signed [VAL_W-1:0] ent     [DEPTH];
  logic signed [VAL_W-1:0] ent_nxt [DEPTH];
  logic [DEPTH-1:0]        vld;
  logic [DEPTH-1:0]        vld_nxt;
  logic [DEPTH-1:0]        ge;
  logic [DEPTH-1:0]        eq;

  logic                    out_valid_r;
  logic [STAT_W-1:0]       out_status_r;
  logic [COUNT_W-1:0]      out_count_r;
  logic signed [VAL_W-1:0] out_top_r;

  // handshake: the result register frees as it is taken
  assign in_tready = !out_valid_r || out_tready;
  assign step      = in_tvalid && in_tready;

  // item decode
  assign full  = (held_r == CNT_W'(DEPTH));
  assign found = |(vld & eq);

  always_comb begin
    ctl.value = in_tdata;
    ctl.ins   = 1'b0;
    ctl.del   = 1'b0;
    held_nxt  = held_r;
    status    = ST_DONE;
    if (in_tuser == CMD_INSERT) begin
      if (full) begin
        status = ST_FULL;
      end else begin
        ctl.ins  = step;
        held_nxt = held_r + CNT_W'(1);
      end
    end else begin
      if (held_r == '0) begin
        status = ST_EMPTY;
      end else if (!found) begin
        status = ST_NOTFOUND;
      end else begin
        ctl.del  = step;
        held_nxt = held_r - CNT_W'(1);
      end
    end
  end

  // row of slots, largest entry in slot 0
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic                    l_vld;
    logic                    l_ge;
    logic signed [VAL_W-1:0] l_ent;
    logic                    r_vld;
    logic signed [VAL_W-1:0] r_ent;

    if (k == 0) begin : g_head
      assign l_vld = 1'b1;
      assign l_ge  = 1'b0;
      assign l_ent = '0;
    end else begin : g_body
      assign l_vld = vld[k-1];
      assign l_ge  = ge[k-1];
      assign l_ent = ent[k-1];
    end

    if (k == DEPTH - 1) begin : g_tail
      assign r_vld = 1'b0;
      assign r_ent = '0;
    end else begin : g_mid
      assign r_vld = vld[k+1];
      assign r_ent = ent[k+1];
    end

    spq_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .left_vld  (l_vld),
      .left_ge   (l_ge),
      .left_ent  (l_ent),
      .right_vld (r_vld),
      .right_ent (r_ent),
      .ent_r     (ent[k]),
      .vld_r     (vld[k]),
      .ge        (ge[k]),
      .eq        (eq[k]),
      .ent_nxt   (ent_nxt[k]),
      .vld_nxt   (vld_nxt[k])
    );
  end

  // count field keeps the low bits of the held count
  assign cnt_ext = {{COUNT_W{1'b0}}, held_nxt};

  // held count and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (step) begin
        held_r      <= held_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (step) begin
      out_status_r <= status;
      out_count_r  <= cnt_ext[COUNT_W-1:0];
      out_top_r    <= vld_nxt[0] ? ent_nxt[0] : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_top_r, out_count_r, out_status_r};

`ifndef SYNTHESIS
  a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= CNT_W'(DEPTH))
    else $error("held count beyond depth");

  a_held_flags: assert property (@(posedge clk) disable iff (!rst_n)
    ($countones(vld) == int'(held_r)) && ((vld & (vld + DEPTH'(1))) == '0))
    else $error("slot flags do not match held count");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    step && (status == ST_FULL) |=> (held_r == CNT_W'(DEPTH)) && out_tvalid)
    else $error("full status with room left");

  a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
    step && (held_nxt == '0) |=> (out_top_r == '0))
    else $error("top value not zero on empty queue");
`endif

endmodule

`default_nettype wire
